// ----- hw/rtl/wsfd_pkg.sv -----
// Shared types and constants for the WebSocket frame decoder.
// No dependencies; imported by wsfd_parser and websocket_frame_decoder.
`default_nettype none

package wsfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned CNT_W   = 4;

    // Header byte fields
    localparam int unsigned MASK_BIT_POS = 7;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;

    // Field lengths in bytes
    localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd1048576;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              empty;
        logic              fatal;
    } wsfd_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wsfd_parser.sv -----
// Frame header parser and payload unmasker: one byte per step.
// Depends on wsfd_pkg for field widths, header constants and the result type.
`default_nettype none

module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [BYTE_W-1:0]   byte_val,
    input  wire logic [LEN_W-1:0]    max_len,
    output logic                     res_valid,
    output wsfd_result_t             res
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [KIND_W-1:0]  opcode_reg, opcode_next;
    logic               mask_reg,   mask_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic               hi_nz_reg,  hi_nz_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [31:0]        key_reg,    key_next;
    logic [1:0]         idx_reg,    idx_next;

    logic [LEN_W-1:0]   cand_len;
    logic               cand_hi;
    logic               too_long;
    logic [BYTE_W-1:0]  key_byte;

    // Length as it stands once this byte is folded in; high bits beyond 32 kept sticky.
    always_comb
    begin
        if (phase_reg == PH_HDR1)
        begin
            cand_len = {{(LEN_W-7){1'b0}}, byte_val[6:0]};
            cand_hi  = 1'b0;
        end
        else
        begin
            cand_len = {len_reg[LEN_W-BYTE_W-1:0], byte_val};
            cand_hi  = hi_nz_reg | (len_reg[LEN_W-1:LEN_W-BYTE_W] != '0);
        end
        too_long = cand_hi || (cand_len > max_len);
    end

    always_comb
    begin
        unique case (idx_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        hi_nz_next  = hi_nz_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        res_valid   = 1'b0;
        res.data    = '0;
        res.kind    = opcode_reg;
        res.last    = 1'b0;
        res.empty   = 1'b0;
        res.fatal   = 1'b0;

        if (step)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = byte_val[KIND_W-1:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_next  = byte_val[MASK_BIT_POS];
                    hi_nz_next = 1'b0;
                    len_next   = '0;
                    if (byte_val[6:0] == LEN_CODE_16)
                    begin
                        cnt_next   = EXT16_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else if (byte_val[6:0] == LEN_CODE_64)
                    begin
                        cnt_next   = EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else if (too_long || !byte_val[MASK_BIT_POS])
                    begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.fatal  = 1'b1;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        len_next   = cand_len;
                        key_next   = '0;
                        cnt_next   = KEY_BYTES;
                        phase_next = PH_MASK;
                    end
                end
                PH_EXTLEN:
                begin
                    len_next   = cand_len;
                    hi_nz_next = cand_hi;
                    cnt_next   = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        if (too_long || !mask_reg)
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.fatal  = 1'b1;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            key_next   = '0;
                            cnt_next   = KEY_BYTES;
                            phase_next = PH_MASK;
                        end
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], byte_val};
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        if (len_reg == '0)
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.empty  = 1'b1;
                            phase_next = PH_HDR0;
                        end
                        else
                        begin
                            idx_next   = 2'd0;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    res.data  = byte_val ^ key_byte;
                    len_next  = len_reg - LEN_W'(1);
                    idx_next  = idx_reg + 2'd1;
                    if (len_reg == {{(LEN_W-1){1'b0}}, 1'b1})
                    begin
                        res.last   = 1'b1;
                        phase_next = PH_HDR0;
                    end
                end
                PH_HALT:
                begin
                    // drop everything until reset
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            len_reg    <= '0;
            hi_nz_reg  <= 1'b0;
            cnt_reg    <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            hi_nz_reg  <= hi_nz_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/websocket_frame_decoder.sv -----
// WebSocket receive-side frame decoder: top level with input and result registers.
// Depends on wsfd_pkg and wsfd_parser.
//
// Usage:
//   Input channel (in_valid / in_stall / byte_in) carries the received byte stream,
//   one byte per transfer. Output channel (out_valid / out_stall and the result
//   fields) carries at most one result per input byte: an unmasked payload byte,
//   an empty-frame marker, or a fatal error marker. Header and mask key bytes
//   produce no result unless they end an empty frame or a frame that fails a check.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes max_frame_len;
//   cfg_ready is always high. Write it only while the block is idle.
// Pipeline and throughput:
//   A transferred byte waits in the input register, passes the parse stage and its result
//   is captured in the result register. One byte per cycle sustained while no result is
//   stalled; the rate is set by the single parse stage between the two registers.
// Reset:
//   rst_n clears the parser to await the first header byte and sets
//   max_frame_len to 1048576. After a fatal error every byte is dropped until reset.
// Stall:
//   While out_stall holds a waiting result, the parse stage holds, the input
//   register fills once and in_stall then rises; no byte or result is lost.
`default_nettype none

module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [BYTE_W-1:0]  byte_in,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [BYTE_W-1:0]       payload_byte,
    output logic [KIND_W-1:0]       frame_kind,
    output logic                    last_of_frame,
    output logic                    empty_frame,
    output logic                    fatal_error,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LEN_W-1:0]   cfg_data
);

    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               out_valid_reg;
    wsfd_result_t       out_res_reg;
    logic [LEN_W-1:0]   max_len_reg;

    logic               advance;
    logic               step;
    logic               res_valid;
    wsfd_result_t       res;

    // The parse stage may advance whenever the result register is free or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    wsfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_val  (s1_byte_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register: load on every transfer, empty once the byte is parsed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= byte_in;
        end
    end

    // Result register: hold while stalled, otherwise take whatever the parser produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_res_reg.data;
    assign frame_kind    = out_res_reg.kind;
    assign last_of_frame = out_res_reg.last;
    assign empty_frame   = out_res_reg.empty;
    assign fatal_error   = out_res_reg.fatal;

endmodule

`default_nettype wire

// ----- tb/tb_websocket_frame_decoder.sv -----
// Self-checking testbench for websocket_frame_decoder: WebSocket frames go in one byte per
// transfer and each unmasked payload byte, empty-frame marker and fatal error is checked.
// Depends on wsfd_pkg and the websocket_frame_decoder RTL only.
module tb_websocket_frame_decoder;
    import wsfd_pkg::*;

    // Cycles with no transfer on any channel before the run is abandoned
    localparam int unsigned QUIET_LIMIT      = 5000;
    // Length of the long receiver hold-off that fills the block up
    localparam int unsigned HOLDOFF_CYCLES   = 300;
    // Only the first few mismatches are printed in full
    localparam int unsigned REPORT_LIMIT     = 10;
    // Minimum input bytes per random phase (four phases)
    localparam int unsigned BYTES_PER_PHASE  = 80;
    // Cycles to let pass after the last result, matching the block's latency with margin
    localparam int unsigned SETTLE_CYCLES    = 4;
    // Largest payload used by random frames, with an occasional longer one
    localparam int unsigned TYPICAL_LEN_CAP  = 48;
    localparam int unsigned LONG_LEN_CAP     = 200;
    // Largest length that fits the 7-bit length code
    localparam int unsigned DIRECT_LEN_MAX   = 125;

    typedef enum logic [2:0] {
        AWAIT_HDR0,
        AWAIT_HDR1,
        AWAIT_EXT_LEN,
        AWAIT_KEY,
        IN_PAYLOAD,
        HALTED
    } frame_phase_t;

    typedef enum logic [1:0] {
        LEN_DIRECT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  byte_in = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [BYTE_W-1:0]  payload_byte;
    logic [KIND_W-1:0]  frame_kind;
    logic               last_of_frame;
    logic               empty_frame;
    logic               fatal_error;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data = '0;

    // Idling rates of the current phase, in percent
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    // Hold-off request from the test sequence, taken up by the receiver process
    int unsigned        holdoff_req = 0;
    int unsigned        holdoff_left = 0;

    int unsigned        bytes_sent = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles = 0;

    // Parser state as the predictor tracks it
    frame_phase_t       frame_phase = AWAIT_HDR0;
    logic [KIND_W-1:0]  cur_kind = '0;
    logic               cur_masked = 1'b0;
    logic [63:0]        len_acc = '0;
    logic [CNT_W-1:0]   field_left = '0;
    logic [31:0]        key_word = '0;
    logic [LEN_W-1:0]   data_left = '0;
    logic [1:0]         key_pos = '0;
    logic [LEN_W-1:0]   max_len_model = MAX_LEN_RESET;

    // Results still owed by the block, oldest first
    wsfd_result_t       expected_results[$];

    websocket_frame_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .frame_kind    (frame_kind),
        .last_of_frame (last_of_frame),
        .empty_frame   (empty_frame),
        .fatal_error   (fatal_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic void push_expected(logic [BYTE_W-1:0] data, logic last_flag,
                                          logic empty_flag, logic fatal_flag);
        wsfd_result_t r;
        r.data  = data;
        r.kind  = cur_kind;
        r.last  = last_flag;
        r.empty = empty_flag;
        r.fatal = fatal_flag;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Length complete: an oversized length wins over a missing mask, and either one
    // halts the parser for good. Otherwise go on to the four key bytes.
    function automatic void close_length();
        if (len_acc > {32'b0, max_len_model} || !cur_masked) begin
            push_expected('0, 1'b1, 1'b0, 1'b1);
            frame_phase = HALTED;
        end
        else begin
            key_word    = '0;
            field_left  = KEY_BYTES;
            frame_phase = AWAIT_KEY;
        end
    endfunction

    // Advance the predicted parser by one accepted byte.
    function automatic void predict_byte(logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] key_b;
        case (frame_phase)
            AWAIT_HDR0:
            begin
                // FIN and RSV bits are ignored
                cur_kind    = b[3:0];
                frame_phase = AWAIT_HDR1;
            end
            AWAIT_HDR1:
            begin
                cur_masked = b[MASK_BIT_POS];
                len_acc    = '0;
                if (b[6:0] == LEN_CODE_16) begin
                    field_left  = EXT16_BYTES;
                    frame_phase = AWAIT_EXT_LEN;
                end
                else if (b[6:0] == LEN_CODE_64) begin
                    field_left  = EXT64_BYTES;
                    frame_phase = AWAIT_EXT_LEN;
                end
                else begin
                    len_acc = {57'b0, b[6:0]};
                    close_length();
                end
            end
            AWAIT_EXT_LEN:
            begin
                len_acc    = {len_acc[55:0], b};
                field_left = field_left - 1'b1;
                if (field_left == '0)
                    close_length();
            end
            AWAIT_KEY:
            begin
                key_word   = {key_word[23:0], b};
                field_left = field_left - 1'b1;
                if (field_left == '0) begin
                    if (len_acc == '0) begin
                        push_expected('0, 1'b1, 1'b1, 1'b0);
                        frame_phase = AWAIT_HDR0;
                    end
                    else begin
                        data_left   = len_acc[LEN_W-1:0];
                        key_pos     = '0;
                        frame_phase = IN_PAYLOAD;
                    end
                end
            end
            IN_PAYLOAD:
            begin
                // First key byte received unmasks payload byte 0
                key_b     = key_word[8 * (3 - key_pos) +: 8];
                data_left = data_left - 1'b1;
                key_pos   = key_pos + 1'b1;
                push_expected(b ^ key_b, data_left == '0, 1'b0, 1'b0);
                if (data_left == '0)
                    frame_phase = AWAIT_HDR0;
            end
            default:
            begin
                // Halted: drop everything until reset
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: random stall, with a counted hold-off on request
    // ---------------------------------------------------------------------

    always @(posedge clk) begin
        if (holdoff_req != 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (holdoff_left != 0) begin
            holdoff_left = holdoff_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Sample at the edge: outputs and stall still hold their pre-edge values here
    always @(posedge clk) begin
        wsfd_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0)
                note_mismatch($sformatf(
                    "unexpected result data=%02h kind=%h last=%b empty=%b fatal=%b",
                    payload_byte, frame_kind, last_of_frame, empty_frame, fatal_error));
            else begin
                want = expected_results.pop_front();
                if (payload_byte !== want.data || frame_kind !== want.kind ||
                    last_of_frame !== want.last || empty_frame !== want.empty ||
                    fatal_error !== want.fatal)
                    note_mismatch($sformatf(
                        {"expected data=%02h kind=%h last=%b empty=%b fatal=%b,",
                         " got data=%02h kind=%h last=%b empty=%b fatal=%b"},
                        want.data, want.kind, want.last, want.empty, want.fatal,
                        payload_byte, frame_kind, last_of_frame, empty_frame,
                        fatal_error));
            end
        end
    end

    // Watchdog: abandon the run after a long stretch with no transfer anywhere
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Offer one byte, idling first at the phase's rate; return at the edge of its transfer.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(b);
        bytes_sent++;
    endtask

    // Drop valid, hold until every owed result has arrived, then let the pipe settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write max_frame_len; call only while the block is idle.
    task automatic write_max_len(input logic [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        max_len_model = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_header(input logic [3:0] kind, input logic [3:0] flag_bits,
                               input logic [63:0] len, input len_form_t form,
                               input logic masked);
        send_byte({flag_bits, kind});
        case (form)
            LEN_EXT16:
            begin
                send_byte({masked, LEN_CODE_16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            LEN_EXT64:
            begin
                send_byte({masked, LEN_CODE_64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
            default:
                send_byte({masked, len[6:0]});
        endcase
    endtask

    // Well-formed masked frame with random key and payload.
    task automatic send_frame(input logic [3:0] kind, input logic [3:0] flag_bits,
                              input int unsigned len, input len_form_t form);
        send_header(kind, flag_bits, 64'(len), form, 1'b1);
        repeat (4) send_byte(BYTE_W'($urandom));
        repeat (len) send_byte(BYTE_W'($urandom));
    endtask

    task automatic send_random_frame();
        int unsigned cap;
        int unsigned len;
        len_form_t   form;
        cap = (max_len_model < TYPICAL_LEN_CAP) ? max_len_model : TYPICAL_LEN_CAP;
        if ($urandom_range(0, 11) == 0 && max_len_model >= LONG_LEN_CAP)
            cap = LONG_LEN_CAP;
        len = $urandom_range(0, cap);
        // Lean on the exact limit now and then
        if ($urandom_range(0, 7) == 0)
            len = cap;
        case ($urandom_range(0, 9))
            0, 1:    form = LEN_EXT16;
            2, 3:    form = LEN_EXT64;
            default: form = (len > DIRECT_LEN_MAX) ? LEN_EXT16 : LEN_DIRECT;
        endcase
        send_frame(KIND_W'($urandom), 4'($urandom), len, form);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Each length form at the reset limit, header flag bits clear and all set.
    task automatic test_header_forms();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_frame(4'h1, 4'h8, 0, LEN_DIRECT);
        send_frame(4'hF, 4'hF, 4, LEN_DIRECT);
        send_frame(4'h0, 4'h0, 0, LEN_EXT16);
        send_frame(4'h2, 4'h8, 3, LEN_EXT64);
        wait_drained();
    endtask

    // Limit at both extremes and a payload exactly at the limit; sweep every opcode.
    task automatic test_length_limits();
        send_idle_pct  = 57;
        recv_stall_pct = 10;
        write_max_len('0);
        for (int k = 0; k < 16; k++)
            send_frame(KIND_W'(k), 4'($urandom), 0, len_form_t'(k % 3));
        wait_drained();
        write_max_len('1);
        send_frame(4'hA, 4'h0, 2, LEN_EXT64);
        wait_drained();
        write_max_len(32'd3);
        send_frame(4'h9, 4'h8, 3, LEN_DIRECT);
        send_frame(4'h8, 4'h8, 3, LEN_EXT64);
        wait_drained();
    endtask

    // Hold the receiver off while bytes keep coming, so the block fills and stalls its input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_max_len(32'd64);
        holdoff_req = HOLDOFF_CYCLES;
        send_frame(4'h2, 4'h8, 40, LEN_DIRECT);
        send_frame(4'h1, 4'h0, 6, LEN_EXT16);
        // Pause the sender until everything owed has come out
        wait_drained();
    endtask

    // Random well-formed traffic under each idling pattern, a fresh limit per phase.
    task automatic test_random_traffic();
        int unsigned start;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_max_len(LEN_W'($urandom_range(1, 60)));
                end
                1:
                begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                    write_max_len('1);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                    write_max_len(LEN_W'($urandom));
                end
                default:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                    write_max_len(LEN_W'($urandom_range(0, 8)));
                end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < BYTES_PER_PHASE)
                send_random_frame();
            wait_drained();
        end
    endtask

    // One fatal frame, oversized or unmasked at random, then noise that must be dropped.
    // Run last: only reset clears the halt.
    task automatic test_fatal_halt();
        logic [63:0] len;
        int unsigned cap;
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        write_max_len(LEN_W'($urandom));
        if ($urandom_range(0, 1) == 1) begin
            // Upper half nonzero: oversized whatever the limit, mask bit irrelevant
            len = {$urandom | 32'h1, $urandom};
            send_header(KIND_W'($urandom), 4'($urandom), len, LEN_EXT64, 1'($urandom));
        end
        else begin
            cap = (max_len_model < 20) ? max_len_model : 20;
            len = 64'($urandom_range(0, cap));
            send_header(KIND_W'($urandom), 4'($urandom), len,
                        ($urandom_range(0, 1) == 1) ? LEN_EXT16 : LEN_DIRECT, 1'b0);
        end
        repeat (16) send_byte(BYTE_W'($urandom));
        wait_drained();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_forms();
        test_length_limits();
        test_backpressure();
        test_random_traffic();
        test_fatal_halt();

        // Allow for a result still in flight after the queue emptied
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived",
                          expected_results.size()));

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_parser.sv
hw/rtl/websocket_frame_decoder.sv
tb/tb_websocket_frame_decoder.sv
